// ----- hw/rtl/ssa_pkg.sv -----
package ssa_pkg;

   localparam int KEY_W   = 8;
   localparam int WORD_W  = 64;
   localparam int COUNT_W = 9;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_GET    = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_VACANT = 2'd1,
      STATUS_FULL   = 2'd2,
      STATUS_RANGE  = 2'd3
   } status_type;

endpackage

// ----- hw/rtl/ssa_ram.sv -----
module ssa_ram #(
   parameter int WIDTH = 65,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/slab_slot_allocator.sv -----
// Channel   Direction  Handshake                Word carried
// req_      in         req_valid / req_stall    mode, slot_key, payload
// rsp_      out        rsp_valid / rsp_stall    key_out, value_out, status, occupied_count
//
// Every operation is accepted in S_IDLE, which issues the read of the slot
// RAM; S_EXEC then evaluates the read data and writes the slot back.
// The read of the slot RAM is registered.
// Reset is synchronous and clears the used size, free head, live count and
// the control flags; the slot RAM itself is not cleared.
// A stalled result sits in the output register while the next word is taken;
// only the write-back of that next word waits for the output register to free.
module slab_slot_allocator #(
   parameter int SLOTS = 256
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_slot_key,
   input  logic [63:0] req_payload,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_key_out,
   output logic [63:0] rsp_value_out,
   output logic [1:0]  rsp_status,
   output logic [8:0]  rsp_occupied_count
);

   // Address width of the slot RAM, and width of counters that reach SLOTS.
   localparam int AW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   // Common width for comparing keys and counters and for the narrow outputs.
   localparam int KW = (CW > ssa_pkg::COUNT_W) ? CW : ssa_pkg::COUNT_W;
   // Each RAM entry is an occupied flag on top of a value or a free link.
   localparam int RW = ssa_pkg::WORD_W + 1;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type                   state_ff, state_in;
   ssa_pkg::mode_type           mode_ff, mode_in;
   logic [ssa_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [ssa_pkg::WORD_W-1:0]  payload_ff, payload_in;
   logic [CW-1:0]               used_ff, used_in;
   logic [CW-1:0]               head_ff, head_in;
   logic [CW-1:0]               live_ff, live_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ssa_pkg::KEY_W-1:0]   rsp_key_ff, rsp_key_in;
   logic [ssa_pkg::WORD_W-1:0]  rsp_value_ff, rsp_value_in;
   ssa_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [ssa_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                        req_take;
   logic                        exec_fire;
   logic [KW-1:0]               rd_sel;

   logic                        ram_we;
   logic [AW-1:0]               ram_waddr;
   logic [RW-1:0]               ram_wdata;
   logic [RW-1:0]               ram_rdata;
   logic                        rd_occ;
   logic [ssa_pkg::WORD_W-1:0]  rd_word;

   // Outcome of the operation held in the request registers.
   logic                        res_we;
   logic [KW-1:0]               res_waddr;
   logic [RW-1:0]               res_wdata;
   logic [ssa_pkg::KEY_W-1:0]   res_key;
   logic [ssa_pkg::WORD_W-1:0]  res_value;
   ssa_pkg::status_type         res_status;
   logic [CW-1:0]               res_used;
   logic [CW-1:0]               res_head;
   logic [CW-1:0]               res_live;
   logic [KW-1:0]               key_ext;
   logic [KW-1:0]               head_ext;
   logic [KW-1:0]               used_ext;
   logic [KW-1:0]               live_ext;

   assign req_take  = (state_ff == S_IDLE) && req_valid;
   assign exec_fire = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);

   // An insert reads the slot at the free head to learn its link; remove and
   // get read the addressed slot. The read is only issued at accept, so the
   // RAM output holds while the write-back waits on a stalled result.
   assign rd_sel = (ssa_pkg::mode_type'(req_mode) == ssa_pkg::MODE_INSERT)
                   ? KW'(head_ff) : KW'(req_slot_key);

   ssa_ram #(
      .WIDTH (RW),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (req_take),
      .rd_addr (rd_sel[AW-1:0]),
      .rd_data (ram_rdata)
   );

   assign rd_occ  = ram_rdata[RW-1];
   assign rd_word = ram_rdata[ssa_pkg::WORD_W-1:0];

   assign key_ext  = KW'(key_ff);
   assign head_ext = KW'(head_ff);
   assign used_ext = KW'(used_ff);

   // Operation evaluation. The read data only matters for slots below the used
   // size, and each of those was written when it was appended, so the read data
   // is valid whenever it matters.
   always_comb begin
      res_we     = 1'b0;
      res_waddr  = key_ext;
      res_wdata  = {1'b0, ssa_pkg::WORD_W'(head_ff)};
      res_key    = key_ff;
      res_value  = '0;
      res_status = ssa_pkg::STATUS_OK;
      res_used   = used_ff;
      res_head   = head_ff;
      res_live   = live_ff;

      case (mode_ff)
         ssa_pkg::MODE_INSERT: begin
            res_waddr = head_ext;
            res_wdata = {1'b1, payload_ff};
            if (head_ff == used_ff) begin
               // Append a fresh slot at the end of the used region.
               if (used_ff >= CW'(SLOTS)) begin
                  res_status = ssa_pkg::STATUS_FULL;
               end else begin
                  res_we   = 1'b1;
                  res_used = head_ff + 1'b1;
                  res_head = head_ff + 1'b1;
                  res_live = live_ff + 1'b1;
                  res_key  = head_ext[ssa_pkg::KEY_W-1:0];
               end
            end else if ((head_ff > used_ff) || (head_ff >= CW'(SLOTS)) || rd_occ) begin
               // A corrupt free head is reported as a full store.
               res_status = ssa_pkg::STATUS_FULL;
            end else begin
               // Reuse a freed slot and follow its link to the next free one.
               res_we = 1'b1;
               if (rd_word > ssa_pkg::WORD_W'(SLOTS)) begin
                  res_head = CW'(SLOTS);
               end else begin
                  res_head = rd_word[CW-1:0];
               end
               res_live = live_ff + 1'b1;
               res_key  = head_ext[ssa_pkg::KEY_W-1:0];
            end
         end
         ssa_pkg::MODE_REMOVE, ssa_pkg::MODE_GET: begin
            if (key_ext >= used_ext) begin
               res_status = ssa_pkg::STATUS_RANGE;
            end else if (!rd_occ) begin
               res_status = ssa_pkg::STATUS_VACANT;
            end else begin
               res_value = rd_word;
               if (mode_ff == ssa_pkg::MODE_REMOVE) begin
                  // Push the slot onto the free list, linking the old head.
                  res_we   = 1'b1;
                  res_head = key_ext[CW-1:0];
                  res_live = live_ff - 1'b1;
               end
            end
         end
         ssa_pkg::MODE_CLEAR: begin
            res_used = '0;
            res_head = '0;
            res_live = '0;
         end
         default: begin
            res_status = ssa_pkg::STATUS_OK;
         end
      endcase
   end

   assign live_ext  = KW'(res_live);
   assign ram_we    = exec_fire && res_we;
   assign ram_waddr = res_waddr[AW-1:0];
   assign ram_wdata = res_wdata;

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      payload_in    = payload_ff;
      used_in       = used_ff;
      head_in       = head_ff;
      live_in       = live_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_key_in    = rsp_key_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      if (req_take) begin
         state_in   = S_EXEC;
         mode_in    = ssa_pkg::mode_type'(req_mode);
         key_in     = req_slot_key;
         payload_in = req_payload;
      end

      if (exec_fire) begin
         state_in      = S_IDLE;
         used_in       = res_used;
         head_in       = res_head;
         live_in       = res_live;
         rsp_valid_in  = 1'b1;
         rsp_key_in    = res_key;
         rsp_value_in  = res_value;
         rsp_status_in = res_status;
         rsp_count_in  = live_ext[ssa_pkg::COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         head_ff      <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         key_ff        <= key_in;
         payload_ff    <= payload_in;
         used_ff       <= used_in;
         head_ff       <= head_in;
         live_ff       <= live_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_key_out        = rsp_key_ff;
   assign rsp_value_out      = rsp_value_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_occupied_count = rsp_count_ff;

   // The occupied slots all lie inside the used region.
   a_live_within_used: assert property (@(posedge clock) disable iff (reset)
      live_ff <= used_ff)
      else $error("live count exceeds used size");

   // The free head never points past the end of the used region.
   a_head_within_used: assert property (@(posedge clock) disable iff (reset)
      head_ff <= used_ff)
      else $error("free head beyond used size");

   // The slot RAM is only written while an operation completes.
   a_write_in_exec: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_EXEC) && exec_fire)
      else $error("slot write outside execution");

   // A completed clear reports an empty store.
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (exec_fire && (mode_ff == ssa_pkg::MODE_CLEAR)) |=>
         (rsp_valid_ff && (rsp_count_ff == '0) && (live_ff == '0)))
      else $error("clear left occupied slots");

endmodule

// ----- dv/slab_slot_allocator_tb.sv -----
module slab_slot_allocator_tb;

   localparam int SLOT_COUNT  = 256;
   // A cycle with no word taken on either channel counts toward this limit. Gaps are
   // capped at MAX_GAP and stalls are random per cycle, so a correct run
   // never gets close to it.
   localparam int QUIET_LIMIT = 4000;
   localparam int PHASE_WORDS = 500;
   localparam int MAX_GAP     = 30;

   // The random part runs in episodes. Each one leans toward a different mix of
   // operations, so that the store fills up to full, drains, and churns its free list.
   typedef enum int {
      EP_FILL,
      EP_CHURN,
      EP_DRAIN
   } episode_kind_type;

   typedef struct {
      logic [ssa_pkg::KEY_W-1:0]   key;
      logic [ssa_pkg::WORD_W-1:0]  value;
      ssa_pkg::status_type         status;
      logic [ssa_pkg::COUNT_W-1:0] count;
   } slot_reply_type;

   // Keeps its own copy of the slot store and predicts the result word of each
   // request word. Free slots hold the link to the next free slot, exactly as the
   // block keeps them, so the order in which keys come back is predicted too.
   class slot_ledger;
      bit                         occ[SLOT_COUNT];
      logic [ssa_pkg::WORD_W-1:0] word[SLOT_COUNT];
      int unsigned                used;
      int unsigned                head;
      int unsigned                live;
      slot_reply_type             replies_due[$];
      int                         errors;

      function void note_word(ssa_pkg::mode_type mode, logic [ssa_pkg::KEY_W-1:0] key,
                              logic [ssa_pkg::WORD_W-1:0] payload);
         slot_reply_type r;
         int unsigned h;
         r.key    = key;
         r.value  = '0;
         r.status = ssa_pkg::STATUS_OK;
         case (mode)
            ssa_pkg::MODE_INSERT: begin
               h = head;
               if (h == used) begin
                  if (used >= SLOT_COUNT) begin
                     r.status = ssa_pkg::STATUS_FULL;
                  end else begin
                     word[h] = payload;
                     occ[h]  = 1'b1;
                     used    = h + 1;
                     head    = h + 1;
                     live++;
                     r.key   = h[ssa_pkg::KEY_W-1:0];
                  end
               end else if (h > used || h >= SLOT_COUNT || occ[h]) begin
                  r.status = ssa_pkg::STATUS_FULL;
               end else begin
                  head    = (word[h] > 64'(SLOT_COUNT)) ? SLOT_COUNT : int'(word[h][31:0]);
                  word[h] = payload;
                  occ[h]  = 1'b1;
                  live++;
                  r.key   = h[ssa_pkg::KEY_W-1:0];
               end
            end
            ssa_pkg::MODE_REMOVE, ssa_pkg::MODE_GET: begin
               if (key >= used) begin
                  r.status = ssa_pkg::STATUS_RANGE;
               end else if (!occ[key]) begin
                  r.status = ssa_pkg::STATUS_VACANT;
               end else begin
                  r.value = word[key];
                  if (mode == ssa_pkg::MODE_REMOVE) begin
                     word[key] = 64'(head);
                     occ[key]  = 1'b0;
                     head      = key;
                     live--;
                  end
               end
            end
            default: begin
               // Clear only rewinds the counters; the occupancy bits go stale but
               // every slot is rewritten when it is appended again.
               used = 0;
               head = 0;
               live = 0;
            end
         endcase
         r.count = live[ssa_pkg::COUNT_W-1:0];
         replies_due.insert(replies_due.size(), r);
      endfunction

      function void check_reply(logic [ssa_pkg::KEY_W-1:0] key,
                                logic [ssa_pkg::WORD_W-1:0] value,
                                ssa_pkg::status_type status,
                                logic [ssa_pkg::COUNT_W-1:0] count);
         slot_reply_type want;
         if (replies_due.size() == 0) begin
            $display("%0t: result word with none expected: key %0d status %0d",
                     $time, key, status);
            errors++;
            return;
         end
         want = replies_due.pop_front();
         if (key !== want.key) begin
            $display("%0t: key_out expected %0d, actual %0d", $time, want.key, key);
            errors++;
         end
         if (value !== want.value) begin
            $display("%0t: value_out expected %h, actual %h", $time, want.value, value);
            errors++;
         end
         if (status !== want.status) begin
            $display("%0t: status expected %0d, actual %0d", $time, want.status, status);
            errors++;
         end
         if (count !== want.count) begin
            $display("%0t: occupied_count expected %0d, actual %0d",
                     $time, want.count, count);
            errors++;
         end
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [1:0]                  req_mode = ssa_pkg::MODE_GET;
   logic [ssa_pkg::KEY_W-1:0]   req_slot_key = '0;
   logic [ssa_pkg::WORD_W-1:0]  req_payload = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [ssa_pkg::KEY_W-1:0]   rsp_key_out;
   logic [ssa_pkg::WORD_W-1:0]  rsp_value_out;
   logic [1:0]                  rsp_status;
   logic [ssa_pkg::COUNT_W-1:0] rsp_occupied_count;

   slot_ledger ledger;
   int         send_idle_pct = 0;
   int         stall_pct = 0;
   int         quiet_cycles = 0;

   slab_slot_allocator #(
      .SLOTS(SLOT_COUNT)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_slot_key       (req_slot_key),
      .req_payload        (req_payload),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_key_out        (rsp_key_out),
      .rsp_value_out      (rsp_value_out),
      .rsp_status         (rsp_status),
      .rsp_occupied_count (rsp_occupied_count)
   );

   always #2 clock = ~clock;

   // The receiver stalls on a fresh random draw every cycle, at the rate of the
   // current phase. A rate of zero gives long stretches with no stall at all.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Result words are checked at the edge that takes them. Everything sampled here
   // was driven by nonblocking assignments, so the values seen are those before
   // the edge, whatever order the processes wake in.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            ledger.check_reply(rsp_key_out, rsp_value_out,
                               ssa_pkg::status_type'(rsp_status), rsp_occupied_count);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // A hung handshake ends the run here.
   always @(posedge clock) begin
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Presents one request word and returns at the edge that takes it. Inputs only
   // change at rising edges, so req_stall is settled during the low half of the
   // clock: once it reads low there, the next rising edge takes the word for sure,
   // and the word is handed to the ledger right away. Noting it before that edge
   // means the next word is always chosen from up-to-date store contents.
   task automatic send_word(ssa_pkg::mode_type mode, logic [ssa_pkg::KEY_W-1:0] key,
                            logic [ssa_pkg::WORD_W-1:0] payload);
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_slot_key <= key;
      req_payload  <= payload;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      ledger.note_word(mode, key, payload);
      @(posedge clock);
   endtask

   // Holds the sender back until every result word still owed has come out.
   task automatic wait_for_replies();
      do @(negedge clock); while (ledger.replies_due.size() != 0);
      @(posedge clock);
   endtask

   // Keys for remove and get: mostly an occupied slot or a slot under the used
   // size, sometimes the first key past it, sometimes any 8-bit key at all.
   function automatic logic [ssa_pkg::KEY_W-1:0] pick_key();
      int unsigned roll;
      int unsigned start;
      int unsigned idx;
      roll = $urandom_range(99);
      if (roll < 50 && ledger.live != 0) begin
         start = $urandom_range(ledger.used - 1);
         for (int n = 0; n < SLOT_COUNT; n++) begin
            idx = (start + n) % ledger.used;
            if (ledger.occ[idx]) return idx[ssa_pkg::KEY_W-1:0];
         end
      end
      if (roll < 80 && ledger.used != 0) begin
         return ssa_pkg::KEY_W'($urandom_range(ledger.used - 1));
      end
      // With all slots in use this wraps to key zero, which is simply in range.
      if (roll < 90) return ssa_pkg::KEY_W'(ledger.used);
      return ssa_pkg::KEY_W'($urandom_range(255));
   endfunction

   function automatic ssa_pkg::mode_type choose_mode(episode_kind_type kind);
      int unsigned roll;
      roll = $urandom_range(999);
      case (kind)
         EP_FILL: begin
            if (roll < 900) return ssa_pkg::MODE_INSERT;
            if (roll < 950) return ssa_pkg::MODE_REMOVE;
            return ssa_pkg::MODE_GET;
         end
         EP_CHURN: begin
            if (roll < 2) return ssa_pkg::MODE_CLEAR;
            if (roll < 400) return ssa_pkg::MODE_INSERT;
            if (roll < 700) return ssa_pkg::MODE_REMOVE;
            return ssa_pkg::MODE_GET;
         end
         default: begin
            if (roll < 2) return ssa_pkg::MODE_CLEAR;
            if (roll < 200) return ssa_pkg::MODE_INSERT;
            if (roll < 800) return ssa_pkg::MODE_REMOVE;
            return ssa_pkg::MODE_GET;
         end
      endcase
   endfunction

   initial begin
      int                         send_pct_of[4];
      int                         stall_pct_of[4];
      episode_kind_type           kind;
      int                         episode_left;
      int                         gap;
      bit                         pause;
      ssa_pkg::mode_type          mode;
      logic [ssa_pkg::WORD_W-1:0] payload;
      int unsigned                roll;

      ledger = new;
      // Idling phases: none, sender only, receiver only, both.
      send_pct_of  = '{0, 58, 0, 30};
      stall_pct_of = '{0, 0, 58, 30};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: reads of an empty store, extreme payloads, a vacant
      // slot, keys just past the used size, reuse of removed slots in last-in
      // first-out order, and a clear followed by a fresh append.
      send_word(ssa_pkg::MODE_GET,    8'd0,   64'h0);
      send_word(ssa_pkg::MODE_REMOVE, 8'hFF,  '1);
      send_word(ssa_pkg::MODE_INSERT, 8'hFF,  64'h0);
      send_word(ssa_pkg::MODE_INSERT, 8'h00,  '1);
      send_word(ssa_pkg::MODE_INSERT, 8'hA5,  64'h5555_5555_5555_5555);
      send_word(ssa_pkg::MODE_INSERT, 8'h5A,  64'hAAAA_AAAA_AAAA_AAAA);
      send_word(ssa_pkg::MODE_GET,    8'd0,   64'h0);
      send_word(ssa_pkg::MODE_GET,    8'd1,   64'h0);
      send_word(ssa_pkg::MODE_GET,    8'd4,   64'h0);
      send_word(ssa_pkg::MODE_GET,    8'd255, 64'h0);
      send_word(ssa_pkg::MODE_REMOVE, 8'd1,   64'h0);
      send_word(ssa_pkg::MODE_REMOVE, 8'd1,   64'h0);
      send_word(ssa_pkg::MODE_GET,    8'd1,   64'h0);
      send_word(ssa_pkg::MODE_REMOVE, 8'd3,   64'h0);
      send_word(ssa_pkg::MODE_INSERT, 8'd0,   64'h8000_0000_0000_0001);
      send_word(ssa_pkg::MODE_INSERT, 8'd0,   64'h0123_4567_89AB_CDEF);
      send_word(ssa_pkg::MODE_INSERT, 8'd0,   64'hFEDC_BA98_7654_3210);
      send_word(ssa_pkg::MODE_CLEAR,  8'd7,   64'h0);
      send_word(ssa_pkg::MODE_GET,    8'd0,   64'h0);
      send_word(ssa_pkg::MODE_INSERT, 8'd9,   64'h7FFF_FFFF_FFFF_FFFE);

      // Random part. The very first episode fills the store, so that the full
      // case is reached early; later ones are picked at random.
      kind         = EP_FILL;
      episode_left = 300;
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = send_pct_of[phase];
         stall_pct     = stall_pct_of[phase];
         for (int i = 0; i < PHASE_WORDS; i++) begin
            if (episode_left == 0) begin
               kind         = episode_kind_type'($urandom_range(2));
               episode_left = $urandom_range(100, 300);
            end
            episode_left--;

            gap = 0;
            while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
            // Every phase opens with the pipeline drained, and now and then the
            // sender also waits mid-phase for all owed results.
            pause = (i == 0) || ($urandom_range(299) == 0);
            if (gap != 0 || pause) begin
               req_valid <= 1'b0;
               if (pause) wait_for_replies();
               repeat (gap) @(posedge clock);
            end

            mode = choose_mode(kind);
            roll = $urandom_range(19);
            if (roll == 0) begin
               payload = '0;
            end else if (roll == 1) begin
               payload = '1;
            end else begin
               payload = {$urandom, $urandom};
            end
            send_word(mode, pick_key(), payload);
         end
      end

      req_valid <= 1'b0;
      wait_for_replies();
      // Run on after that so that a stray extra result word would still show up.
      repeat (8) @(posedge clock);
      if (ledger.replies_due.size() != 0) begin
         $display("%0t: %0d result words expected but never seen",
                  $time, ledger.replies_due.size());
         ledger.errors++;
      end

      if (ledger.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
